// ===== hdl/rtq_pkg.sv =====
// Shared types, constants and codes for the repeating timer queue.
`default_nettype none
package rtq_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int SLOT_W      = $clog2(TIMER_SLOTS);

    // Command codes
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_ADDED    = 2'd0;
    localparam logic [1:0] KIND_FIRED    = 2'd1;
    localparam logic [1:0] KIND_REJ_ZERO = 2'd2;
    localparam logic [1:0] KIND_REJ_FULL = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [23:0] period_ticks;
        logic [15:0] repeat_count;
        logic [15:0] target_id;
    } request_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] result_id;
        logic        last;
    } result_t;

    // Per-slot timer payload; age is only meaningful while fire is set
    typedef struct packed {
        logic [30:0] age;
        logic [31:0] deadline;
        logic [23:0] period;
        logic [15:0] remaining;
        logic [15:0] ident;
    } timer_t;

    typedef struct packed {
        logic   valid;
        logic   fire;
        timer_t data;
    } entry_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_ADD,
        OP_DELETE,
        OP_AGE,
        OP_SORT,
        OP_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     phase;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/rtq_cell.sv =====
// One timer slot of the chain: holds an entry, sorts with its neighbors, shifts left.
`default_nettype none
module rtq_cell
    import rtq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cell_ctrl_t  ctrl,
    input  wire logic        pos_odd,
    input  wire logic        free_in,
    output logic             free_out,
    input  wire timer_t      add_data,
    input  wire logic [31:0] now,
    input  wire logic [15:0] target_id,
    input  wire entry_t      left_entry,
    input  wire entry_t      right_entry,
    input  wire logic        left_swap,
    output logic             swap_out,
    output entry_t           entry
);

    logic   valid_reg, valid_next;
    logic   fire_reg, fire_next;
    timer_t data_reg, data_next;
    logic   take_add;
    logic [31:0] diff;
    logic   expired;
    logic   right_first;

    assign entry    = '{valid: valid_reg, fire: fire_reg, data: data_reg};
    assign free_out = free_in | ~valid_reg;
    assign take_add = ~valid_reg & ~free_in;
    assign diff     = now - data_reg.deadline;
    assign expired  = ~diff[31];

    // right neighbor goes first: it fires, and this one does not, or it is older, or equal age and lower id
    assign right_first = right_entry.fire &
        (~fire_reg || (right_entry.data.age > data_reg.age) ||
         ((right_entry.data.age == data_reg.age) &&
          (right_entry.data.ident < data_reg.ident)));
    assign swap_out = (ctrl.op == OP_SORT) && (pos_odd == ctrl.phase) && right_first;

    always_comb
    begin
        valid_next = valid_reg;
        fire_next  = fire_reg;
        data_next  = data_reg;
        case (ctrl.op)
            OP_ADD:
            begin
                if (take_add)
                begin
                    valid_next = 1'b1;
                    fire_next  = 1'b0;
                    data_next  = add_data;
                end
            end
            OP_DELETE:
            begin
                if (valid_reg && (data_reg.ident == target_id))
                begin
                    data_next.remaining = '0;
                end
            end
            OP_AGE:
            begin
                data_next.age = diff[30:0];
                fire_next     = valid_reg & expired & (data_reg.remaining != '0);
                if (valid_reg && expired && (data_reg.remaining == '0))
                begin
                    valid_next = 1'b0;
                end
            end
            OP_SORT:
            begin
                if (swap_out)
                begin
                    valid_next = right_entry.valid;
                    fire_next  = right_entry.fire;
                    data_next  = right_entry.data;
                end
                else if (left_swap)
                begin
                    valid_next = left_entry.valid;
                    fire_next  = left_entry.fire;
                    data_next  = left_entry.data;
                end
            end
            OP_SHIFT:
            begin
                valid_next = right_entry.valid;
                fire_next  = right_entry.fire;
                data_next  = right_entry.data;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            fire_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            fire_reg  <= fire_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule
`default_nettype wire

// ===== hdl/repeating_timer_queue_top.sv =====
// Top level of the repeating timer queue: command FSM around a chain of timer cells.
//
//  channel   | signals                     | direction | handshake
//  ----------+-----------------------------+-----------+------------------------------
//  request   | start, busy, request        | in        | taken when start && !busy
//  result    | result_valid, result        | out       | one-cycle strobe, no stall
//
// Add and delete requests finish in the accepting cycle; busy stays low and an add
// answers in the next cycle. A tick holds busy through an aging step, TIMER_SLOTS
// odd-even transposition rounds across the cell chain, then one fired result per
// cycle as the chain shifts left (one emit step when none fired). Reset clears time,
// the id counter and every valid bit at once; no clearing pass. Results cannot be
// stalled, so none is ever held back.
`default_nettype none
module repeating_timer_queue_top
    import rtq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire request_t request,
    output logic          result_valid,
    output result_t       result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_AGE,
        ST_SORT,
        ST_EMIT
    } state_t;

    localparam logic [SLOT_W-1:0] SORT_LAST = SLOT_W'(TIMER_SLOTS - 1);

    state_t            state_reg;
    logic [31:0]       now_reg;
    logic [15:0]       next_ident_reg;
    logic [SLOT_W-1:0] round_reg;
    logic              result_valid_reg;
    result_t           result_reg;

    cell_ctrl_t        ctrl;
    entry_t            cell_q   [TIMER_SLOTS];
    entry_t            left_in  [TIMER_SLOTS];
    entry_t            right_in [TIMER_SLOTS];
    logic [TIMER_SLOTS:0]   free_chain;
    logic [TIMER_SLOTS-1:0] swap_r;
    entry_t            retire;
    timer_t            add_data;
    logic [23:0]       add_period;
    logic              accept;
    logic              full;
    logic [15:0]       rem_dec;

    assign busy         = (state_reg != ST_IDLE);
    assign accept       = start && !busy;
    assign full         = ~free_chain[TIMER_SLOTS];
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // New entry: a zero period counts as one tick
    assign add_period = (request.period_ticks == '0) ? 24'd1 : request.period_ticks;
    assign add_data   = '{age:       '0,
                          deadline:  now_reg + {8'd0, add_period},
                          period:    add_period,
                          remaining: request.repeat_count,
                          ident:     next_ident_reg};

    // Head entry after firing: re-arm from now or drop when the count runs out
    assign rem_dec = cell_q[0].data.remaining - 16'd1;
    always_comb
    begin
        retire                = cell_q[0];
        retire.fire           = 1'b0;
        retire.valid          = (rem_dec != '0);
        retire.data.remaining = rem_dec;
        retire.data.deadline  = now_reg + {8'd0, cell_q[0].data.period};
    end

    // Broadcast control to the chain
    always_comb
    begin
        ctrl = '{op: OP_HOLD, phase: 1'b0};
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (request.command == CMD_ADD) &&
                    (request.repeat_count != '0) && !full)
                begin
                    ctrl.op = OP_ADD;
                end
                else if (accept && (request.command == CMD_DELETE))
                begin
                    ctrl.op = OP_DELETE;
                end
            end
            ST_AGE:
            begin
                ctrl.op = OP_AGE;
            end
            ST_SORT:
            begin
                ctrl.op    = OP_SORT;
                ctrl.phase = round_reg[0];
            end
            ST_EMIT:
            begin
                if (cell_q[0].fire)
                begin
                    ctrl.op = OP_SHIFT;
                end
            end
            default:
            begin
                ctrl.op = OP_HOLD;
            end
        endcase
    end

    assign free_chain[0] = 1'b0;

    for (genvar i = 0; i < TIMER_SLOTS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign left_in[i] = '0;
        end
        else
        begin : g_body
            assign left_in[i] = cell_q[i-1];
        end
        if (i == TIMER_SLOTS - 1)
        begin : g_tail
            assign right_in[i] = retire;
        end
        else
        begin : g_mid
            assign right_in[i] = cell_q[i+1];
        end

        rtq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .pos_odd     (1'(i % 2)),
            .free_in     (free_chain[i]),
            .free_out    (free_chain[i+1]),
            .add_data    (add_data),
            .now         (now_reg),
            .target_id   (request.target_id),
            .left_entry  (left_in[i]),
            .right_entry (right_in[i]),
            .left_swap   ((i == 0) ? 1'b0 : swap_r[(i == 0) ? 0 : i - 1]),
            .swap_out    (swap_r[i]),
            .entry       (cell_q[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            now_reg          <= '0;
            next_ident_reg   <= '0;
            round_reg        <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (request.command)
                            CMD_ADD:
                            begin
                                result_valid_reg <= 1'b1;
                                result_reg.last  <= 1'b1;
                                if (request.repeat_count == '0)
                                begin
                                    result_reg.result_kind <= KIND_REJ_ZERO;
                                    result_reg.result_id   <= '0;
                                end
                                else if (full)
                                begin
                                    result_reg.result_kind <= KIND_REJ_FULL;
                                    result_reg.result_id   <= '0;
                                end
                                else
                                begin
                                    result_reg.result_kind <= KIND_ADDED;
                                    result_reg.result_id   <= next_ident_reg;
                                    next_ident_reg         <= next_ident_reg + 16'd1;
                                end
                            end
                            CMD_TICK:
                            begin
                                now_reg   <= now_reg + 32'd1;
                                state_reg <= ST_AGE;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_AGE:
                begin
                    round_reg <= '0;
                    state_reg <= ST_SORT;
                end
                ST_SORT:
                begin
                    round_reg <= round_reg + 1'b1;
                    if (round_reg == SORT_LAST)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (cell_q[0].fire)
                    begin
                        result_valid_reg       <= 1'b1;
                        result_reg.result_kind <= KIND_FIRED;
                        result_reg.result_id   <= cell_q[0].data.ident;
                        result_reg.last        <= ~cell_q[1].fire;
                        if (!cell_q[1].fire)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Fired results come only out of the emit phase
    a_fired_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.result_kind == KIND_FIRED) |-> $past(state_reg) == ST_EMIT)
        else $error("fired result outside emit phase");

    // After sorting, firing entries form a prefix of the chain
    a_fire_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && cell_q[1].fire |-> cell_q[0].fire)
        else $error("firing entries not sorted to the head");

    // An accepted add always answers in the next cycle as the final result
    a_add_answers: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (request.command == CMD_ADD) |=> result_valid && result.last)
        else $error("add request without a single final result");

    // An accepted tick always occupies the block
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (request.command == CMD_TICK) |=> busy && (state_reg == ST_AGE))
        else $error("tick request did not start aging");

    // A fired result marked last ends the tick
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.result_kind == KIND_FIRED) && result.last |-> !busy)
        else $error("block still busy after final fired result");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the repeating timer queue: random and directed requests.
`default_nettype none
module tb;
    import rtq_pkg::*;

    // Command code 3 has no meaning; the block must ignore it.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Quiet-cycle limit. The longest legal stretch with nothing accepted is a sender gap
    // plus a tick that fires nothing, or a drain pause of the same order; the limit is
    // far beyond either.
    localparam int WATCHDOG_LIMIT = 1000;
    // Settle time at the end: longer than a tick can keep the block busy.
    localparam int SETTLE_CYCLES  = 2 * TIMER_SLOTS + 8;
    localparam int RANDOM_ITEMS   = 100;

    logic     clk;
    logic     rst_n   = 1'b0;
    logic     start   = 1'b0;
    request_t request = '0;
    logic     busy;
    logic     result_valid;
    result_t  result;

    repeating_timer_queue_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Timer table predictor. Updated at the edge where a request is taken,
    // it pushes the results that request must produce, in order.
    // ------------------------------------------------------------------
    logic [31:0] clock_now;
    logic [15:0] ident_next;
    logic        slot_live     [TIMER_SLOTS];
    logic [31:0] slot_deadline [TIMER_SLOTS];
    logic [23:0] slot_period   [TIMER_SLOTS];
    logic [15:0] slot_left     [TIMER_SLOTS];
    logic [15:0] slot_ident    [TIMER_SLOTS];

    result_t timer_events_due[$];   // results still owed by the block, oldest first

    initial
    begin
        clock_now  = '0;
        ident_next = '0;
        for (int s = 0; s < TIMER_SLOTS; s++)
            slot_live[s] = 1'b0;
    end

    task automatic apply_timer_request(input request_t r);
        int          slot;
        int          best;
        logic [31:0] age;
        logic [31:0] best_age;
        result_t     fired[$];
        case (r.command)
            CMD_ADD:
            begin
                slot = -1;
                for (int s = TIMER_SLOTS - 1; s >= 0; s--)
                    if (!slot_live[s])
                        slot = s;
                if (r.repeat_count == '0)
                    timer_events_due.push_back('{result_kind: KIND_REJ_ZERO,
                                                 result_id: '0, last: 1'b1});
                else if (slot < 0)
                    timer_events_due.push_back('{result_kind: KIND_REJ_FULL,
                                                 result_id: '0, last: 1'b1});
                else
                begin
                    // zero period behaves as one tick
                    slot_period[slot]   = (r.period_ticks == '0) ? 24'd1 : r.period_ticks;
                    slot_live[slot]     = 1'b1;
                    slot_deadline[slot] = clock_now + slot_period[slot];
                    slot_left[slot]     = r.repeat_count;
                    slot_ident[slot]    = ident_next;
                    timer_events_due.push_back('{result_kind: KIND_ADDED,
                                                 result_id: ident_next, last: 1'b1});
                    ident_next = ident_next + 16'd1;
                end
            end
            CMD_DELETE:
            begin
                // every live entry with this id, duplicates after id wrap included
                for (int s = 0; s < TIMER_SLOTS; s++)
                    if (slot_live[s] && slot_ident[s] == r.target_id)
                        slot_left[s] = '0;
            end
            CMD_TICK:
            begin
                clock_now = clock_now + 32'd1;
                while (1)
                begin
                    // oldest expired entry; equal age goes to lower id, then lower slot
                    best     = -1;
                    best_age = '0;
                    for (int s = 0; s < TIMER_SLOTS; s++)
                    begin
                        if (!slot_live[s])
                            continue;
                        age = clock_now - slot_deadline[s];
                        if (age[31])
                            continue;
                        if (best < 0 || age > best_age ||
                            (age == best_age && slot_ident[s] < slot_ident[best]))
                        begin
                            best     = s;
                            best_age = age;
                        end
                    end
                    if (best < 0)
                        break;
                    // a deleted entry is dropped without a result
                    if (slot_left[best] != '0)
                    begin
                        fired.push_back('{result_kind: KIND_FIRED,
                                          result_id: slot_ident[best], last: 1'b0});
                        slot_left[best] = slot_left[best] - 16'd1;
                    end
                    if (slot_left[best] == '0)
                        slot_live[best] = 1'b0;
                    else
                        slot_deadline[best] = clock_now + slot_period[best];
                end
                if (fired.size() != 0)
                    fired[fired.size() - 1].last = 1'b1;
                foreach (fired[i])
                    timer_events_due.push_back(fired[i]);
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Request driver. Requests come from pending_requests in bursts with
    // random gaps. A request flagged wait_idle is held back until the block
    // is idle and owes nothing.
    // ------------------------------------------------------------------
    typedef struct {
        request_t req;
        bit       wait_idle;
    } stim_item_t;

    stim_item_t pending_requests[$];
    int         burst_left;
    int         gap_left;

    always @(posedge clk or negedge rst_n)
    begin : request_driver
        stim_item_t head;
        logic       raise;
        logic       drained;
        if (!rst_n)
        begin
            start      <= 1'b0;
            request    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            // a request not taken this edge stays up unchanged
            raise   = start && busy;
            // nothing taken at this edge, nothing running, nothing owed
            drained = !start && !busy && timer_events_due.size() == 0;
            if (start && !busy)
                apply_timer_request(request);
            if (!raise && pending_requests.size() != 0)
            begin
                if (gap_left > 0)
                    gap_left = gap_left - 1;
                else if (!pending_requests[0].wait_idle || drained)
                begin
                    head = pending_requests.pop_front();
                    request <= head.req;
                    raise = 1'b1;
                    if (burst_left > 0)
                        burst_left = burst_left - 1;
                    else
                    begin
                        // mostly short bursts, now and then a long unbroken one
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(0, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            start <= raise;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: every strobe is matched against the oldest result owed.
    // ------------------------------------------------------------------
    int mismatch_count = 0;

    task automatic note_mismatch(input string why, input result_t want, input result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected kind %0d id %0d last %0d, got kind %0d id %0d last %0d",
                     $realtime, why, want.result_kind, want.result_id, want.last,
                     got.result_kind, got.result_id, got.last);
    endtask

    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (rst_n && result_valid)
        begin
            if (timer_events_due.size() == 0)
                note_mismatch("result with none owed", '0, result);
            else
            begin
                want = timer_events_due.pop_front();
                if (result.result_kind !== want.result_kind ||
                    result.result_id !== want.result_id ||
                    result.last !== want.last)
                    note_mismatch("wrong result", want, result);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: counts cycles with neither a request taken nor a result.
    // ------------------------------------------------------------------
    int quiet_cycles;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((start && !busy) || result_valid)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic request_t make_request(input logic [1:0] cmd, input logic [23:0] per,
                                              input logic [15:0] rep, input logic [15:0] tgt);
        request_t r;
        r.command      = cmd;
        r.period_ticks = per;
        r.repeat_count = rep;
        r.target_id    = tgt;
        return r;
    endfunction

    task automatic queue_request(input request_t r, input bit wait_idle);
        stim_item_t item;
        item.req       = r;
        item.wait_idle = wait_idle;
        pending_requests.push_back(item);
    endtask

    // Sampled at the falling edge, when the driver and the block have settled.
    task automatic wait_until_idle();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || start || busy || timer_events_due.size() != 0);
    endtask

    initial
    begin : stimulus
        int          random_count;
        int          chunk;
        int          pick;
        logic [15:0] tgt;
        logic [15:0] rep;
        logic [23:0] per;
        logic [15:0] live_ids[$];

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- Directed part -------------------------------------------
        // zero repeat is rejected and does not use up an id
        queue_request(make_request(CMD_ADD, 24'd5, 16'd0, 16'd0), 0);
        // zero period fires on the very next tick
        queue_request(make_request(CMD_ADD, 24'd0, 16'd1, 16'd0), 0);
        // largest period and count: parks in a slot for the rest of the run
        queue_request(make_request(CMD_ADD, 24'hFFFFFF, 16'hFFFF, 16'hFFFF), 0);
        // unused code and a delete of an unknown id: both silent
        queue_request(make_request(CMD_UNUSED, 24'hFFFFFF, 16'hFFFF, 16'hFFFF), 0);
        queue_request(make_request(CMD_DELETE, 24'hFFFFFF, 16'hFFFF, 16'hFFFF), 0);
        queue_request(make_request(CMD_TICK, 24'h0, 16'h0, 16'h0), 0);
        // fill every free slot with equal deadlines, then overflow the table
        repeat (TIMER_SLOTS - 1)
            queue_request(make_request(CMD_ADD, 24'd1, 16'd2, 16'd0), 0);
        queue_request(make_request(CMD_ADD, 24'd1, 16'd7, 16'd0), 0);
        // all fire on one tick in id order; then a deleted one drops out silently
        queue_request(make_request(CMD_TICK, 24'h0, 16'h0, 16'h0), 0);
        queue_request(make_request(CMD_DELETE, 24'h0, 16'h0, 16'd5), 0);
        queue_request(make_request(CMD_TICK, 24'h0, 16'h0, 16'h0), 0);
        wait_until_idle();

        // --- Random part ---------------------------------------------
        // Generated a few at a time so deletes can aim at timers that are live.
        random_count = 0;
        chunk        = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            while (pending_requests.size() != 0)
                @(negedge clk);
            live_ids.delete();
            for (int s = 0; s < TIMER_SLOTS; s++)
                if (slot_live[s])
                    live_ids.push_back(slot_ident[s]);
            for (int k = 0; k < 8; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                begin
                    pick = $urandom_range(0, 99);
                    rep  = (pick < 10) ? 16'd0 :
                           (pick < 17) ? 16'($urandom) : 16'($urandom_range(1, 4));
                    per  = ($urandom_range(0, 49) == 0) ? 24'($urandom)
                                                        : 24'($urandom_range(0, 6));
                    queue_request(make_request(CMD_ADD, per, rep, 16'($urandom)),
                                  k == 0 && (chunk == 0 || $urandom_range(0, 3) == 0));
                end
                else if (pick < 50)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 7 && live_ids.size() != 0)
                        tgt = live_ids[$urandom_range(0, live_ids.size() - 1)];
                    else if (pick < 9)
                        tgt = 16'(ident_next - $urandom_range(0, 3));
                    else
                        tgt = 16'($urandom);
                    queue_request(make_request(CMD_DELETE, 24'($urandom), 16'($urandom), tgt),
                                  k == 0 && (chunk == 0 || $urandom_range(0, 3) == 0));
                end
                else if (pick < 95)
                    queue_request(make_request(CMD_TICK, 24'($urandom), 16'($urandom),
                                               16'($urandom)),
                                  k == 0 && (chunk == 0 || $urandom_range(0, 3) == 0));
                else
                    queue_request(make_request(CMD_UNUSED, 24'($urandom), 16'($urandom),
                                               16'($urandom)), 0);
                if (pick < 95)
                    random_count++;
            end
            chunk++;
        end

        wait_until_idle();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && timer_events_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire
